/* rtl/tspk_pkg.sv */
// Shared types, field widths, key layout constants and the factorial weight function.
package tspk_pkg;

    localparam int RANK_W       = 19;
    localparam int COUNT_W      = 4;
    localparam int KEY_W        = 32;
    localparam int MASK_SHIFT   = 19;
    localparam int BCOUNT_SHIFT = 28;
    localparam int MASK_W       = BCOUNT_SHIFT - MASK_SHIFT;
    localparam int SUM_W        = COUNT_W + 1;

    typedef logic [RANK_W-1:0]  rank_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [MASK_W-1:0]  occ_mask_t;

    // Sideband that travels next to the rank data through every stage.
    typedef struct packed {
        logic   count_error;
        count_t a_count;
        count_t b_count;
    } side_t;

    // n! for the small n used here; evaluated on constants only.
    function automatic rank_t factorial(input int n);
        int    k;
        rank_t f;
        begin
            f = rank_t'(1);
            for (k = 2; k <= n; k++)
            begin
                f = rank_t'(int'(f) * k);
            end
            return f;
        end
    endfunction

endpackage

/* rtl/tspk_ifs.sv */
// Valid/ready channel interfaces for the input item and the result key.
interface tspk_item_if #(
    parameter int VALUES_W = 36
);
    logic                  valid;
    logic                  ready;
    logic [VALUES_W-1:0]   stacked_values;
    tspk_pkg::count_t      a_count;
    tspk_pkg::count_t      b_count;

    modport source (output valid, output stacked_values, output a_count, output b_count,
                    input ready);
    modport sink   (input valid, input stacked_values, input a_count, input b_count,
                    output ready);
endinterface

interface tspk_key_if;
    logic              valid;
    logic              ready;
    tspk_pkg::rank_t   perm_rank;
    tspk_pkg::key_t    state_key;
    logic              count_error;

    modport source (output valid, output perm_rank, output state_key, output count_error,
                    input ready);
    modport sink   (input valid, input perm_rank, input state_key, input count_error,
                    output ready);
endinterface

/* rtl/tspk_count.sv */
// Stage 1: count the later values smaller than each position and check the stack counts.
module tspk_count #(
    parameter int ELEMENT_COUNT = 9,
    parameter int ELEMENT_BITS  = 4
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        item_valid,
    output logic                                        item_ready,
    input  logic [ELEMENT_COUNT*ELEMENT_BITS-1:0]       values,
    input  tspk_pkg::count_t                            a_count,
    input  tspk_pkg::count_t                            b_count,
    output logic                                        counts_valid,
    input  logic                                        counts_ready,
    output logic [ELEMENT_COUNT-1:0][$clog2(ELEMENT_COUNT)-1:0] counts,
    output tspk_pkg::side_t                             side
);

    localparam int CNT_W = $clog2(ELEMENT_COUNT);

    logic [ELEMENT_COUNT-1:0][ELEMENT_BITS-1:0] vals;
    logic [ELEMENT_COUNT-1:0][CNT_W-1:0]        counts_next;
    logic [ELEMENT_COUNT-1:0][CNT_W-1:0]        counts_reg;
    tspk_pkg::side_t                            side_next;
    tspk_pkg::side_t                            side_reg;
    logic                                       valid_reg;

    assign vals = values;

    always_comb
    begin
        for (int i = 0; i < ELEMENT_COUNT; i++)
        begin
            counts_next[i] = '0;
            for (int j = 0; j < ELEMENT_COUNT; j++)
            begin
                if (j > i && vals[j] < vals[i])
                begin
                    counts_next[i] = counts_next[i] + CNT_W'(1);
                end
            end
        end
        side_next.a_count     = a_count;
        side_next.b_count     = b_count;
        side_next.count_error = (tspk_pkg::SUM_W'(a_count) + tspk_pkg::SUM_W'(b_count))
                                != tspk_pkg::SUM_W'(ELEMENT_COUNT);
    end

    // Advance when the register is empty or its content moves on.
    assign item_ready = !valid_reg || counts_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            counts_reg <= counts_next;
            side_reg   <= side_next;
        end
    end

    assign counts_valid = valid_reg;
    assign counts       = counts_reg;
    assign side         = side_reg;

endmodule

/* rtl/tspk_weight.sv */
// Stage 2: weight each smaller-count by the factorial of the positions left.
module tspk_weight #(
    parameter int ELEMENT_COUNT = 9
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                counts_valid,
    output logic                                                counts_ready,
    input  logic [ELEMENT_COUNT-1:0][$clog2(ELEMENT_COUNT)-1:0] counts,
    input  tspk_pkg::side_t                                     side,
    output logic                                                products_valid,
    input  logic                                                products_ready,
    output tspk_pkg::rank_t [ELEMENT_COUNT-1:0]                 products,
    output tspk_pkg::side_t                                     products_side
);

    tspk_pkg::rank_t [ELEMENT_COUNT-1:0] products_next;
    tspk_pkg::rank_t [ELEMENT_COUNT-1:0] products_reg;
    tspk_pkg::side_t                     side_reg;
    logic                                valid_reg;

    // Constant multiplies; each product stays below ELEMENT_COUNT!.
    always_comb
    begin
        for (int i = 0; i < ELEMENT_COUNT; i++)
        begin
            products_next[i] = tspk_pkg::rank_t'(tspk_pkg::rank_t'(counts[i])
                               * tspk_pkg::factorial(ELEMENT_COUNT - 1 - i));
        end
    end

    assign counts_ready = !valid_reg || products_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (counts_ready)
        begin
            valid_reg <= counts_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (counts_ready && counts_valid)
        begin
            products_reg <= products_next;
            side_reg     <= side;
        end
    end

    assign products_valid = valid_reg;
    assign products       = products_reg;
    assign products_side  = side_reg;

endmodule

/* rtl/tspk_accum.sv */
// Stages 3 and 4: sum the weighted counts in groups, then total them and assemble the key.
module tspk_accum #(
    parameter int ELEMENT_COUNT = 9
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                products_valid,
    output logic                                products_ready,
    input  tspk_pkg::rank_t [ELEMENT_COUNT-1:0] products,
    input  tspk_pkg::side_t                     products_side,
    output logic                                result_valid,
    input  logic                                result_ready,
    output tspk_pkg::rank_t                     perm_rank,
    output tspk_pkg::key_t                      state_key,
    output logic                                count_error
);

    localparam int GROUP_COUNT = (ELEMENT_COUNT + 2) / 3;

    tspk_pkg::rank_t [GROUP_COUNT-1:0] group_next;
    tspk_pkg::rank_t [GROUP_COUNT-1:0] group_reg;
    tspk_pkg::side_t                   side_reg;
    logic                              group_valid_reg;
    logic                              group_ready;

    tspk_pkg::rank_t                   total;
    tspk_pkg::occ_mask_t               occ_mask;
    tspk_pkg::rank_t                   rank_next;
    tspk_pkg::key_t                    key_next;
    tspk_pkg::rank_t                   rank_reg;
    tspk_pkg::key_t                    key_reg;
    logic                              error_reg;
    logic                              result_valid_reg;

    // Groups of three products.
    always_comb
    begin
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < 3; k++)
            begin
                if (3 * g + k < ELEMENT_COUNT)
                begin
                    group_next[g] = group_next[g] + products[3 * g + k];
                end
            end
        end
    end

    // Total, occupancy mask and key; a count mismatch forces zeros.
    always_comb
    begin
        total = '0;
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            total = total + group_reg[g];
        end
        for (int k = 0; k < tspk_pkg::MASK_W; k++)
        begin
            occ_mask[k] = side_reg.a_count > tspk_pkg::COUNT_W'(k);
        end
        if (side_reg.count_error)
        begin
            rank_next = '0;
            key_next  = '0;
        end
        else
        begin
            rank_next = total;
            key_next  = {side_reg.b_count, occ_mask, total};
        end
    end

    assign group_ready    = !result_valid_reg || result_ready;
    assign products_ready = !group_valid_reg || group_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (products_ready)
            begin
                group_valid_reg <= products_valid;
            end
            if (group_ready)
            begin
                result_valid_reg <= group_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (products_ready && products_valid)
        begin
            group_reg <= group_next;
            side_reg  <= products_side;
        end
        if (group_ready && group_valid_reg)
        begin
            rank_reg  <= rank_next;
            key_reg   <= key_next;
            error_reg <= side_reg.count_error;
        end
    end

    assign result_valid = result_valid_reg;
    assign perm_rank    = rank_reg;
    assign state_key    = key_reg;
    assign count_error  = error_reg;

endmodule

/* rtl/two_stack_permutation_rank_key.sv */
// Top level: four-stage pipeline that turns a two-stack split into a Lehmer rank and a key.
//
//   Channel | Role   | Payload
//   --------+--------+-------------------------------------------------------
//   item    | sink   | stacked_values, a_count, b_count
//   key     | source | perm_rank, state_key, count_error
//
// One request is taken per cycle unless a stalled key output backs up to stage 1.
// Stages: compare/count, factorial weighting, group sums, total and key assembly.
// Reset clears the stage valid bits only; payload registers load on advance.
// Each stage holds while it is full and the next one stalls, and fills whenever it is
// empty, so bubbles close up and a stalled result never blocks upstream empty stages.
module two_stack_permutation_rank_key #(
    parameter int ELEMENT_COUNT = 9,
    parameter int ELEMENT_BITS  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    tspk_item_if.sink         item,
    tspk_key_if.source        key
);

    localparam int CNT_W = $clog2(ELEMENT_COUNT);
    localparam tspk_pkg::rank_t RANK_LIMIT = tspk_pkg::factorial(ELEMENT_COUNT);

    // Stage 1 to stage 2
    logic                                counts_valid;
    logic                                counts_ready;
    logic [ELEMENT_COUNT-1:0][CNT_W-1:0] counts;
    tspk_pkg::side_t                     counts_side;

    // Stage 2 to stage 3
    logic                                products_valid;
    logic                                products_ready;
    tspk_pkg::rank_t [ELEMENT_COUNT-1:0] products;
    tspk_pkg::side_t                     products_side;

    // Count smaller successors and flag a stack count mismatch.
    tspk_count #(
        .ELEMENT_COUNT (ELEMENT_COUNT),
        .ELEMENT_BITS  (ELEMENT_BITS)
    ) u_count (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .values       (item.stacked_values[ELEMENT_COUNT*ELEMENT_BITS-1:0]),
        .a_count      (item.a_count),
        .b_count      (item.b_count),
        .counts_valid (counts_valid),
        .counts_ready (counts_ready),
        .counts       (counts),
        .side         (counts_side)
    );

    // Weight counts by the factorial of the remaining positions.
    tspk_weight #(
        .ELEMENT_COUNT (ELEMENT_COUNT)
    ) u_weight (
        .clk            (clk),
        .rst_n          (rst_n),
        .counts_valid   (counts_valid),
        .counts_ready   (counts_ready),
        .counts         (counts),
        .side           (counts_side),
        .products_valid (products_valid),
        .products_ready (products_ready),
        .products       (products),
        .products_side  (products_side)
    );

    // Sum the weights and pack rank, occupancy mask and second-stack count.
    tspk_accum #(
        .ELEMENT_COUNT (ELEMENT_COUNT)
    ) u_accum (
        .clk            (clk),
        .rst_n          (rst_n),
        .products_valid (products_valid),
        .products_ready (products_ready),
        .products       (products),
        .products_side  (products_side),
        .result_valid   (key.valid),
        .result_ready   (key.ready),
        .perm_rank      (key.perm_rank),
        .state_key      (key.state_key),
        .count_error    (key.count_error)
    );

    // A good split always ranks below ELEMENT_COUNT!.
    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        key.valid && !key.count_error |-> key.perm_rank < RANK_LIMIT)
        else $error("perm_rank out of range");

    // A count mismatch must zero both result fields.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        key.valid && key.count_error |-> key.perm_rank == '0 && key.state_key == '0)
        else $error("count_error result not zero");

    // Occupancy bits plus second-stack count must cover all elements.
    a_key_counts: assert property (@(posedge clk) disable iff (!rst_n)
        key.valid && !key.count_error |->
        $countones(key.state_key[tspk_pkg::MASK_SHIFT +: tspk_pkg::MASK_W])
        + int'(key.state_key[tspk_pkg::BCOUNT_SHIFT +: tspk_pkg::COUNT_W]) == ELEMENT_COUNT)
        else $error("key counts do not add up");

    // Low key field carries the rank itself.
    a_key_rank: assert property (@(posedge clk) disable iff (!rst_n)
        key.valid |-> key.state_key[tspk_pkg::RANK_W-1:0] == key.perm_rank)
        else $error("key rank field mismatch");

endmodule
